/* hdl/sle_pkg.sv */
// Shared types, character codes and helpers for the string literal escaper.
`default_nettype none

package sle_pkg;

	// Encoding register codes; codes above the UTF-8 code behave as plain ASCII.
	localparam logic [2:0] ENC_ASCII   = 3'd0;
	localparam logic [2:0] ENC_GB2312  = 3'd1;
	localparam logic [2:0] ENC_GBK     = 3'd2;
	localparam logic [2:0] ENC_GB18030 = 3'd3;
	localparam logic [2:0] ENC_BIG5    = 3'd4;
	localparam logic [2:0] ENC_UTF8    = 3'd5;

	// Characters the escaper emits on its own.
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	// Depth of the command queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// What the back has to do with one command.
	typedef enum logic [1:0] {
		CMD_LIT,  // one character as it is
		CMD_ESC,  // backslash, then the character
		CMD_DEC   // backslash and three decimal digits of the byte
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic       done;
		logic       run_last;
	} cmd_t;

	// Front sequencer states.
	typedef enum logic [2:0] {
		F_IDLE,
		F_OPEN,
		F_DECIDE,
		F_MULTI,
		F_CLOSE,
		F_END
	} front_state_t;

	function automatic logic in_rng(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
		return (v >= lo) && (v <= hi);
	endfunction

endpackage

`default_nettype wire

/* hdl/sle_if.sv */
// Valid/ready channel interfaces for the input bytes and the output characters.
`default_nettype none

interface sle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       has_byte;
	logic       last_in;

	modport source(output valid, output in_byte, output has_byte, output last_in,
		input ready);
	modport sink(input valid, input in_byte, input has_byte, input last_in,
		output ready);
endinterface

interface sle_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       run_last;
	logic       string_done;

	modport source(output valid, output out_char, output run_last, output string_done,
		input ready);
	modport sink(input valid, input out_char, input run_last, input string_done,
		output ready);
endinterface

`default_nettype wire

/* hdl/sle_front.sv */
// Front: takes input bytes into the lookahead window and turns them into commands.
`default_nettype none

module sle_front import sle_pkg::*; #(
	parameter int WINDOW_DEPTH = 6
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [2:0] encoding,
	sle_in_if.sink          in_ch,
	output logic            push,
	output cmd_t            push_cmd,
	input  wire logic       q_full
);

	localparam int FW = $clog2(WINDOW_DEPTH + 1);
	localparam int IW = $clog2(WINDOW_DEPTH);

	front_state_t state_q, state_d;
	logic [7:0]   win_q [WINDOW_DEPTH];
	logic [FW-1:0] fill_q;
	logic         last_q;
	logic         quote_q;
	logic [2:0]   rem_q;
	cmd_t         pend_q;
	logic         pend_valid_q;

	logic         accept;
	logic         take;
	logic         can;
	logic [7:0]   c0, c1, c2, c3;
	logic [7:0]   esc_char;
	logic         is_print;
	logic [2:0]   u8_len;
	logic         u8_cont_ok;
	logic         gbk2;
	logic [2:0]   mb_used;
	logic         gen;
	cmd_t         gen_cmd;
	logic         shift;
	logic         go_multi;
	logic         quote_set;
	logic         quote_clr;

	assign in_ch.ready = (state_q == F_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;

	assign c0 = win_q[0];
	assign c1 = win_q[1];
	assign c2 = win_q[2];
	assign c3 = win_q[3];

	// A group is decided when the window is full, or while a last item flushes it.
	assign take = (fill_q == FW'(WINDOW_DEPTH)) || (last_q && (fill_q != '0));

	// A new command may be made when the held one has room in the queue.
	assign can = !pend_valid_q || !q_full;

	// Short backslash escapes.
	always_comb begin
		unique case (c0)
			8'h07:   esc_char = 8'h61;
			8'h08:   esc_char = 8'h62;
			8'h0C:   esc_char = 8'h66;
			8'h0A:   esc_char = 8'h6E;
			8'h0D:   esc_char = 8'h72;
			8'h09:   esc_char = 8'h74;
			8'h0B:   esc_char = 8'h76;
			8'h5C:   esc_char = 8'h5C;
			8'h22:   esc_char = 8'h22;
			8'h27:   esc_char = 8'h27;
			default: esc_char = 8'h00;
		endcase
	end

	assign is_print = (c0 >= 8'h20) && (c0 < 8'h7F);

	// UTF-8 sequence length from the lead byte; zero for a byte that cannot lead.
	always_comb begin
		priority if (c0 < 8'h80) u8_len = 3'd1;
		else if (c0 < 8'hC0)     u8_len = 3'd0;
		else if (c0 < 8'hE0)     u8_len = 3'd2;
		else if (c0 < 8'hF0)     u8_len = 3'd3;
		else if (c0 < 8'hF8)     u8_len = 3'd4;
		else if (c0 < 8'hFC)     u8_len = 3'd5;
		else if (c0 < 8'hFE)     u8_len = 3'd6;
		else                     u8_len = 3'd0;
	end

	// Every byte inside the sequence after the lead must be a continuation byte.
	always_comb begin
		u8_cont_ok = 1'b1;
		for (int i = 1; i < 6; i++) begin
			if ((3'(i) < u8_len) && (win_q[i][7:6] != 2'b10)) u8_cont_ok = 1'b0;
		end
	end

	assign gbk2 = (fill_q >= FW'(2)) && in_rng(c0, 8'h81, 8'hFE)
		&& in_rng(c1, 8'h40, 8'hFE) && (c1 != 8'h7F);

	// Length of a valid multibyte group at the head, or zero.
	always_comb begin
		mb_used = 3'd0;
		unique case (encoding)
			ENC_GB2312: begin
				if ((fill_q >= FW'(2)) && in_rng(c0, 8'hA1, 8'hF7) && in_rng(c1, 8'hA1, 8'hFE))
					mb_used = 3'd2;
			end
			ENC_GBK: begin
				if (gbk2) mb_used = 3'd2;
			end
			ENC_GB18030: begin
				if (gbk2) begin
					mb_used = 3'd2;
				end else if ((fill_q >= FW'(4)) && in_rng(c0, 8'h81, 8'hFE)
					&& in_rng(c1, 8'h30, 8'h39) && in_rng(c2, 8'h81, 8'hFE)
					&& in_rng(c3, 8'h30, 8'h39)) begin
					mb_used = 3'd4;
				end
			end
			ENC_BIG5: begin
				if ((fill_q >= FW'(2)) && in_rng(c0, 8'h81, 8'hFE)
					&& (in_rng(c1, 8'h40, 8'h7E) || in_rng(c1, 8'hA1, 8'hFE)))
					mb_used = 3'd2;
			end
			ENC_UTF8: begin
				if ((u8_len >= 3'd2) && (fill_q >= FW'(u8_len)) && u8_cont_ok)
					mb_used = u8_len;
			end
			default: begin
				mb_used = 3'd0;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept && (in_ch.has_byte || in_ch.last_in))
					state_d = quote_q ? F_DECIDE : F_OPEN;
			end
			F_OPEN: begin
				if (can) state_d = F_DECIDE;
			end
			F_DECIDE: begin
				if (take) begin
					if (can && go_multi) state_d = F_MULTI;
				end else begin
					state_d = last_q ? F_CLOSE : F_END;
				end
			end
			F_MULTI: begin
				if (can && (rem_q == 3'd1)) state_d = F_DECIDE;
			end
			F_CLOSE: begin
				if (can) state_d = F_END;
			end
			F_END: begin
				if (can) state_d = F_IDLE;
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	// Commands made in each state.
	always_comb begin
		gen       = 1'b0;
		gen_cmd   = '{kind: CMD_LIT, data: c0, done: 1'b0, run_last: 1'b0};
		shift     = 1'b0;
		go_multi  = 1'b0;
		quote_set = 1'b0;
		quote_clr = 1'b0;
		unique case (state_q)
			F_OPEN: begin
				gen          = 1'b1;
				gen_cmd.data = CH_QUOTE;
				quote_set    = 1'b1;
			end
			F_DECIDE: begin
				if (take) begin
					gen   = 1'b1;
					shift = 1'b1;
					if (esc_char != 8'h00) begin
						gen_cmd.kind = CMD_ESC;
						gen_cmd.data = esc_char;
					end else if (is_print) begin
						gen_cmd.kind = CMD_LIT;
					end else if (mb_used != 3'd0) begin
						gen_cmd.kind = CMD_LIT;
						go_multi     = 1'b1;
					end else begin
						gen_cmd.kind = CMD_DEC;
					end
				end
			end
			F_MULTI: begin
				gen   = 1'b1;
				shift = 1'b1;
			end
			F_CLOSE: begin
				gen          = 1'b1;
				gen_cmd.data = CH_QUOTE;
				gen_cmd.done = 1'b1;
				quote_clr    = 1'b1;
			end
			default: begin
				gen = 1'b0;
			end
		endcase
	end

	// The held command goes out when the next one is made, or marked last at the end.
	assign push = pend_valid_q && !q_full && (gen || (state_q == F_END));

	always_comb begin
		push_cmd          = pend_q;
		push_cmd.run_last = (state_q == F_END);
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_IDLE;
			fill_q       <= '0;
			last_q       <= 1'b0;
			quote_q      <= 1'b0;
			rem_q        <= 3'd0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q <= in_ch.last_in;
				if (in_ch.has_byte) fill_q <= fill_q + FW'(1);
			end
			if (gen && can) begin
				pend_valid_q <= 1'b1;
				if (shift) fill_q <= fill_q - FW'(1);
				if (quote_set) quote_q <= 1'b1;
				if (quote_clr) quote_q <= 1'b0;
				if (go_multi) rem_q <= mb_used - 3'd1;
				else if (state_q == F_MULTI) rem_q <= rem_q - 3'd1;
			end else if ((state_q == F_END) && can) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Window and held command payload.
	always_ff @(posedge clk) begin
		if (accept && in_ch.has_byte) begin
			win_q[fill_q[IW-1:0]] <= in_ch.in_byte;
		end else if (gen && can && shift) begin
			for (int i = 0; i < WINDOW_DEPTH - 1; i++) win_q[i] <= win_q[i+1];
		end
		if (gen && can) pend_q <= gen_cmd;
	end

endmodule

`default_nettype wire

/* hdl/sle_fifo.sv */
// Short command queue between the front and the back.
`default_nettype none

module sle_fifo import sle_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty
);

	cmd_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_AW:0]   count_q;

	assign full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QUEUE_AW'(1);
			if (pop) rd_q <= rd_q + QUEUE_AW'(1);
			if (push && !pop) count_q <= count_q + (QUEUE_AW+1)'(1);
			else if (pop && !push) count_q <= count_q - (QUEUE_AW+1)'(1);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

/* hdl/sle_back.sv */
// Back: expands queued commands into characters, one per cycle unless stalled.
`default_nettype none

module sle_back import sle_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t head,
	input  wire logic empty,
	output logic      pop,
	sle_out_if.source out_ch
);

	logic       cur_valid_q;
	cmd_t       cur_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       run_last_q;
	logic       done_q;

	logic       adv;
	logic       fin;
	logic [7:0] ch;
	logic [1:0] hund;
	logic [7:0] rest8;
	logic [6:0] rest;
	logic [3:0] tens;
	logic [6:0] tens_x10;
	logic [6:0] ones7;

	assign out_ch.valid       = out_valid_q;
	assign out_ch.out_char    = out_char_q;
	assign out_ch.run_last    = run_last_q;
	assign out_ch.string_done = done_q;

	// A character moves into the output register when it is empty or being taken.
	assign adv = cur_valid_q && (!out_valid_q || out_ch.ready);

	// Last character of the current command.
	always_comb begin
		unique case (cur_q.kind)
			CMD_LIT: fin = (idx_q == 2'd0);
			CMD_ESC: fin = (idx_q == 2'd1);
			CMD_DEC: fin = (idx_q == 2'd3);
			default: fin = 1'b1;
		endcase
	end

	assign pop = !empty && (!cur_valid_q || (adv && fin));

	// Decimal digits of the byte by comparison against multiples of ten.
	always_comb begin
		if (cur_q.data >= 8'd200) hund = 2'd2;
		else if (cur_q.data >= 8'd100) hund = 2'd1;
		else hund = 2'd0;
		rest8 = cur_q.data - 8'(hund) * 8'd100;
		rest  = rest8[6:0];
		tens  = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (rest >= 7'(k * 10)) tens = tens + 4'd1;
		end
		tens_x10 = 7'(tens) * 7'd10;
		ones7    = rest - tens_x10;
	end

	// Character for the current position in the command.
	always_comb begin
		ch = cur_q.data;
		unique case (cur_q.kind)
			CMD_LIT: ch = cur_q.data;
			CMD_ESC: ch = (idx_q == 2'd0) ? CH_BSLASH : cur_q.data;
			CMD_DEC: begin
				unique case (idx_q)
					2'd0:    ch = CH_BSLASH;
					2'd1:    ch = CH_ZERO + 8'(hund);
					2'd2:    ch = CH_ZERO + 8'(tens);
					default: ch = CH_ZERO + 8'(ones7[3:0]);
				endcase
			end
			default: ch = cur_q.data;
		endcase
	end

	// Command tracking and output handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (adv && fin) begin
				cur_valid_q <= 1'b0;
				idx_q       <= 2'd0;
			end else if (adv) begin
				idx_q <= idx_q + 2'd1;
			end
			if (adv) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// Command and output payload.
	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
		if (adv) begin
			out_char_q <= ch;
			run_last_q <= cur_q.run_last && fin;
			done_q     <= cur_q.done && fin;
		end
	end

endmodule

`default_nettype wire

/* hdl/string_literal_escaper.sv */
// String literal escaper: raw string bytes in, a quoted and escaped literal out.
//
// in_ch carries one item per string byte (in_byte with has_byte set); an item with
// last_in set ends the string, and may carry a byte as well. out_ch carries one
// character of the literal per item; run_last marks the final character caused by an
// input item and string_done marks the closing quote. Both use valid/ready.
// The encoding register (cfg_we, cfg_wdata) selects which multibyte groups pass
// through; it must be written between strings, which the block does not enforce.
// Input bytes wait in a WINDOW_DEPTH-byte lookahead window; a group is decided only
// when the window is full or the string ends, so output lags input by up to
// WINDOW_DEPTH bytes. The front accepts an item only when idle, then makes its
// commands one by one (one per byte of a group, one per quote), then finds no
// group left and ends the item, so it takes no new item until done with the last.
// The back emits one character per cycle while the receiver is ready, up to four
// per byte. A four-entry command queue lets the front run ahead while the receiver
// stalls; a stalled receiver holds the output register and, once the queue fills,
// stops the front and input acceptance.
// Reset empties the window and queue, closes the quote and selects ASCII.
`default_nettype none

module string_literal_escaper import sle_pkg::*; #(
	parameter int WINDOW_DEPTH = 6
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_wdata,
	sle_in_if.sink          in_ch,
	sle_out_if.source       out_ch
);

	logic [2:0] encoding_q;
	logic       push;
	cmd_t       push_cmd;
	logic       q_full;
	logic       pop;
	cmd_t       head;
	logic       q_empty;

	// Encoding register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encoding_q <= ENC_ASCII;
		end else if (cfg_we) begin
			encoding_q <= cfg_wdata;
		end
	end

	sle_front #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.encoding (encoding_q),
		.in_ch    (in_ch),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	sle_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	sle_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (q_empty),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire
